FILE: rtl/core/flca_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the free-list cell allocator.
// No dependencies; imported by flca_link_ram and free_list_cell_allocator_unit.
package flca_pkg;

   localparam int KIND_W     = 2;
   localparam int COUNT_W    = 13;
   localparam int CELL_W     = 12;
   localparam int GRANT_W    = 12;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;

   localparam logic [KIND_W-1:0] KIND_ALLOC_ONE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ALLOC_RUN = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FREE_CELL = 2'd2;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_POP,
      ST_WALK,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/core/free_list_cell_allocator_unit.sv
`timescale 1ns / 1ps
// Free-list cell allocator top level: request decode, walk sequencer, result register.
// Depends on flca_pkg and flca_link_ram.
//
//  channel | direction | tdata                            | tuser
//  req_    | in        | count[12:0], cell_index[24:13]   | kind[1:0]
//  rsp_    | out       | granted_index[11:0]              | out_of_cells[0]
//
// Sequencing: a free, an unused kind, an allocate run of count 0 or an immediate failure
// finishes when accepted; allocate one passes through ST_POP; allocate run walks in
// ST_WALK, one link memory read per link, and stops where it meets the end of the list.
// Reset: a sweep writes cell i -> i+1 for every cell; req_tready stays low meanwhile.
// Stalls: a finished result sits in the output register; the next item is accepted while
// it waits, and a second result holds in the sequencer until the output register frees.
module free_list_cell_allocator_unit
   import flca_pkg::*;
#(
   parameter int POOL_CELLS = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // count[12:0], cell_index[24:13], zero fill
   input  logic [KIND_W-1:0]     req_tuser,   // kind[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // granted_index[11:0], zero fill
   output logic [0:0]            rsp_tuser    // out_of_cells[0]
);

   localparam int CW = $clog2(POOL_CELLS);
   localparam int LW = $clog2(POOL_CELLS + 1);
   localparam logic [LW-1:0] END_MARK  = LW'(POOL_CELLS);
   localparam logic [CW-1:0] LAST_CELL = CW'(POOL_CELLS - 1);

   state_type state_ff, state_in;
   logic [LW-1:0]      head_ff, head_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [CW-1:0]      init_ff, init_in;
   logic [GRANT_W-1:0] pend_grant_ff, pend_grant_in;
   logic               pend_fail_ff, pend_fail_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [GRANT_W-1:0] rsp_grant_ff, rsp_grant_in;
   logic               rsp_fail_ff, rsp_fail_in;

   logic [KIND_W-1:0]  req_kind;
   logic [COUNT_W-1:0] req_count;
   logic [CELL_W-1:0]  req_cell_index;
   logic               req_fire;
   logic               head_empty;
   logic               slot_free;

   logic               fin;
   logic [GRANT_W-1:0] fin_grant;
   logic               fin_fail;

   logic               wr_en;
   logic [CW-1:0]      wr_addr;
   logic [LW-1:0]      wr_data;
   logic [CW-1:0]      rd_addr;
   logic [LW-1:0]      rd_data;

   assign req_kind       = req_tuser;
   assign req_count      = req_tdata[COUNT_W-1:0];
   assign req_cell_index = req_tdata[COUNT_W+CELL_W-1:COUNT_W];
   assign req_fire       = req_tvalid && req_tready;
   assign head_empty     = (head_ff >= END_MARK);
   assign slot_free      = !rsp_valid_ff || rsp_tready;

   flca_link_ram #(
      .DEPTH (POOL_CELLS),
      .AW    (CW),
      .DW    (LW)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Next state, sequencer datapath and link memory commands.
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      rem_in        = rem_ff;
      init_in       = init_ff;
      pend_grant_in = pend_grant_ff;
      pend_fail_in  = pend_fail_ff;
      fin           = 1'b0;
      fin_grant     = '0;
      fin_fail      = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = head_ff[CW-1:0];
      wr_data       = head_ff;
      rd_addr       = head_ff[CW-1:0];

      case (state_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_addr = init_ff;
            wr_data = LW'(init_ff) + LW'(1);
            init_in = init_ff + CW'(1);
            if (init_ff == LAST_CELL) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (req_kind)
                  KIND_ALLOC_ONE: begin
                     if (head_empty) begin
                        fin      = 1'b1;
                        fin_fail = 1'b1;
                     end else begin
                        state_in = ST_POP;
                     end
                  end
                  KIND_ALLOC_RUN: begin
                     if (head_empty) begin
                        fin      = 1'b1;
                        fin_fail = 1'b1;
                     end else if (req_count == '0) begin
                        // hand out the head without popping
                        fin       = 1'b1;
                        fin_grant = GRANT_W'(head_ff);
                     end else begin
                        rem_in   = req_count - COUNT_W'(1);
                        state_in = ST_WALK;
                     end
                  end
                  KIND_FREE_CELL: begin
                     fin = 1'b1;
                     if (32'(req_cell_index) < 32'(POOL_CELLS)) begin
                        wr_en   = 1'b1;
                        wr_addr = CW'(req_cell_index);
                        wr_data = head_ff;
                        head_in = LW'(req_cell_index);
                     end
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end
         ST_POP: begin
            fin       = 1'b1;
            fin_grant = GRANT_W'(head_ff);
            head_in   = rd_data;
         end
         ST_WALK: begin
            if (rem_ff == '0) begin
               fin       = 1'b1;
               fin_grant = GRANT_W'(head_ff);
               head_in   = rd_data;
            end else if (rd_data >= END_MARK) begin
               // list ends before the run is complete: leave the head alone
               fin      = 1'b1;
               fin_fail = 1'b1;
            end else begin
               rd_addr = rd_data[CW-1:0];
               rem_in  = rem_ff - COUNT_W'(1);
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // hold the result in the sequencer when the output register is still full
      if (fin) begin
         pend_grant_in = fin_grant;
         pend_fail_in  = fin_fail;
         state_in      = slot_free ? ST_IDLE : ST_DONE;
      end
   end

   // Port side: handshake and output register loads.
   always_comb begin
      req_tready   = (state_ff == ST_IDLE);
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_grant_in = rsp_grant_ff;
      rsp_fail_in  = rsp_fail_ff;
      if (fin && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_grant_in = fin_grant;
         rsp_fail_in  = fin_fail;
      end else if (state_ff == ST_DONE && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_grant_in = pend_grant_ff;
         rsp_fail_in  = pend_fail_ff;
      end
      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = RSP_DATA_W'(rsp_grant_ff);
      rsp_tuser  = rsp_fail_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         head_ff      <= '0;
         init_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      pend_grant_ff <= pend_grant_in;
      pend_fail_ff  <= pend_fail_in;
      rsp_grant_ff  <= rsp_grant_in;
      rsp_fail_ff   <= rsp_fail_in;
   end

   a_head_in_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= END_MARK)
      else $error("free head beyond end mark");

   a_free_pushes: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_kind == KIND_FREE_CELL && 32'(req_cell_index) < 32'(POOL_CELLS)
      |=> head_ff == LW'($past(req_cell_index)))
      else $error("freed cell did not become the head");

   a_fail_keeps_head: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK && fin && fin_fail |=> $stable(head_ff))
      else $error("failed run allocation moved the head");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && !slot_free |=> state_ff == ST_DONE && rsp_valid_ff)
      else $error("pending result lost while output stalled");

endmodule

FILE: rtl/core/flca_link_ram.sv
`timescale 1ns / 1ps
// Link memory of the allocator: one write port, one read port, registered read data.
// Depends on flca_pkg; used by free_list_cell_allocator_unit.
module flca_link_ram
   import flca_pkg::*;
#(
   parameter int DEPTH = 4096,
   parameter int AW    = 12,
   parameter int DW    = 13
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: tb/tb_free_list_cell_allocator_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for free_list_cell_allocator_unit: directed and random
// allocate/free traffic checked against a shadow free list. Depends on flca_pkg.
module tb_free_list_cell_allocator_unit
   import flca_pkg::*;
();

   localparam int POOL         = 4096;
   localparam int PHASE_ITEMS  = 470;
   localparam int NOISE_ITEMS  = 150;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 50;
   localparam int CYCLE_LIMIT  = 1000000;

   localparam logic [KIND_W-1:0]  KIND_UNUSED = 2'd3;
   localparam logic [COUNT_W-1:0] LIST_END    = 13'(POOL);

   typedef struct packed {
      logic [GRANT_W-1:0] granted_index;
      logic               out_of_cells;
   } grant_type;

   // Shadow of the link memory and head; predicts one grant per accepted item.
   class free_list_shadow;
      logic [COUNT_W-1:0] link_mem [POOL];
      logic [COUNT_W-1:0] head;
      grant_type          grants_due [$];
      logic [CELL_W-1:0]  held_cells [$];
      int                 mismatch_count;

      function new();
         for (int i = 0; i < POOL; i++)
            link_mem[i] = 13'(i + 1);
         head = '0;
         mismatch_count = 0;
      endfunction

      function void note_request(input logic [KIND_W-1:0] kind,
                                 input logic [COUNT_W-1:0] count,
                                 input logic [CELL_W-1:0] cell_id);
         logic [COUNT_W-1:0] walk;
         logic [GRANT_W-1:0] granted;
         logic               fail;
         int                 steps;
         granted = '0;
         fail    = 1'b0;
         case (kind)
            KIND_ALLOC_ONE: begin
               if (head >= LIST_END) begin
                  fail = 1'b1;
               end else begin
                  granted = head[GRANT_W-1:0];
                  held_cells.push_back(head[CELL_W-1:0]);
                  head = link_mem[head[CELL_W-1:0]];
               end
            end
            KIND_ALLOC_RUN: begin
               walk  = head;
               steps = 0;
               if (head >= LIST_END)
                  fail = 1'b1;
               // walk is bounded by count, so a looped list still ends
               while (!fail && steps < count) begin
                  if (walk >= LIST_END) begin
                     fail = 1'b1;
                  end else begin
                     walk = link_mem[walk[CELL_W-1:0]];
                     steps++;
                  end
               end
               if (!fail) begin
                  granted = head[GRANT_W-1:0];
                  for (steps = 0; steps < count; steps++) begin
                     held_cells.push_back(head[CELL_W-1:0]);
                     head = link_mem[head[CELL_W-1:0]];
                  end
               end
            end
            KIND_FREE_CELL: begin
               link_mem[cell_id] = head;
               head = {1'b0, cell_id};
            end
            default: ;
         endcase
         grants_due.push_back('{granted_index: granted, out_of_cells: fail});
      endfunction

      function void check_grant(input logic [GRANT_W-1:0] granted, input logic oom);
         grant_type due;
         if (grants_due.size() == 0) begin
            $display("%0t: unexpected grant: expected none, actual index %0d out_of_cells %0b",
                     $time, granted, oom);
            mismatch_count++;
         end else begin
            due = grants_due.pop_front();
            if (granted !== due.granted_index) begin
               $display("%0t: granted_index expected %0d actual %0d",
                        $time, due.granted_index, granted);
               mismatch_count++;
            end
            if (oom !== due.out_of_cells) begin
               $display("%0t: out_of_cells expected %0b actual %0b",
                        $time, due.out_of_cells, oom);
               mismatch_count++;
            end
         end
      endfunction

      function void drop_held(input logic [CELL_W-1:0] cell_id);
         int i;
         i = 0;
         while (i < held_cells.size() && held_cells[i] != cell_id)
            i++;
         if (i < held_cells.size())
            held_cells.delete(i);
      endfunction

      function logic [CELL_W-1:0] take_held();
         int                slot;
         logic [CELL_W-1:0] cell_id;
         slot = $urandom_range(held_cells.size() - 1);
         cell_id = held_cells[slot];
         held_cells.delete(slot);
         return cell_id;
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // count[12:0], cell_index[24:13], zero fill
   logic [KIND_W-1:0]     req_tuser  = '0;   // kind[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // granted_index[11:0], zero fill
   logic [0:0]            rsp_tuser;         // out_of_cells[0]

   free_list_shadow shadow = new();

   int          tx_idle_pct = 23;
   int          rx_idle_pct = 77;
   bit          hold_go     = 1'b0;
   bit          hold_done   = 1'b0;
   int unsigned hold_left   = 0;
   int unsigned cycle_count = 0;

   free_list_cell_allocator_unit #(.POOL_CELLS(POOL)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 0;
   end

   // Receiver: check each accepted item, then pick next ready (random, or a long hold).
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
         shadow.check_grant(rsp_tdata[GRANT_W-1:0], rsp_tuser[0]);
      if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_go && !hold_done) begin
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic offer_request(input logic [KIND_W-1:0] kind,
                                input logic [COUNT_W-1:0] count,
                                input logic [CELL_W-1:0] cell_id);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({cell_id, count});
      req_tuser  <= kind;
      @(posedge clock);
      while (req_tready !== 1'b1)
         @(posedge clock);
      shadow.note_request(kind, count, cell_id);
   endtask

   task automatic free_cell(input logic [CELL_W-1:0] cell_id);
      shadow.drop_held(cell_id);
      offer_request(KIND_FREE_CELL, '0, cell_id);
   endtask

   task automatic random_request(input bit allow_double_free);
      int                 pick;
      logic [COUNT_W-1:0] count;
      logic [CELL_W-1:0]  cell_id;
      pick    = $urandom_range(99);
      count   = 13'($urandom_range(POOL));
      cell_id = 12'($urandom_range(POOL - 1));
      if (pick < 4) begin
         offer_request(KIND_UNUSED, count, cell_id);
      end else if (pick < 26) begin
         offer_request(KIND_ALLOC_ONE, count, cell_id);
      end else if (pick < 45) begin
         // mostly short runs, now and then a long one
         if ($urandom_range(99) != 0)
            count = 13'($urandom_range(3));
         offer_request(KIND_ALLOC_RUN, count, cell_id);
      end else if (allow_double_free && pick < 55) begin
         // free a random cell, sometimes the head itself, which may already be free
         if (pick == 45 && shadow.head < LIST_END)
            cell_id = shadow.head[CELL_W-1:0];
         free_cell(cell_id);
      end else if (shadow.held_cells.size() != 0) begin
         offer_request(KIND_FREE_CELL, count, shadow.take_held());
      end else begin
         offer_request(KIND_ALLOC_ONE, count, cell_id);
      end
   endtask

   task automatic run_random(input int tx_pct, input int rx_pct, input bit noisy_tail);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      for (int n = 0; n < PHASE_ITEMS; n++)
         random_request(noisy_tail && n >= PHASE_ITEMS - NOISE_ITEMS);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      offer_request(KIND_ALLOC_ONE, '0, '0);
      offer_request(KIND_ALLOC_RUN, 13'd0, '0);       // count zero: head, no pop
      offer_request(KIND_ALLOC_RUN, 13'd1, '0);
      free_cell(12'd0);
      offer_request(KIND_UNUSED, 13'd4096, 12'd4095);
      offer_request(KIND_ALLOC_RUN, 13'd4096, '0);    // one cell short
      offer_request(KIND_ALLOC_RUN, 13'd4095, '0);    // takes every free cell
      offer_request(KIND_ALLOC_ONE, '0, '0);          // empty list
      offer_request(KIND_ALLOC_RUN, 13'd0, '0);
      offer_request(KIND_ALLOC_RUN, 13'd1, '0);
      free_cell(12'd4095);
      free_cell(12'd0);
      free_cell(12'd2048);
      offer_request(KIND_ALLOC_RUN, 13'd4, '0);
      offer_request(KIND_ALLOC_RUN, 13'd3, '0);
      free_cell(12'hAAA);
      free_cell(12'h555);
      free_cell(12'hFFE);
      free_cell(12'd1);
      offer_request(KIND_ALLOC_RUN, 13'd2, 12'hFFF);
      offer_request(KIND_ALLOC_ONE, 13'h1000, 12'hFFF);
      offer_request(KIND_ALLOC_ONE, '0, '0);

      run_random(23, 77, 1'b0);
      run_random(77, 23, 1'b0);
      // hold the receiver off so the block backs up into its input
      hold_go <= 1'b1;
      run_random(0, 0, 1'b1);
      req_tvalid <= 1'b0;

      while (shadow.grants_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shadow.mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
